// ===== rtl/kv_cache_replacement_defines.svh =====
// Assertion macros used by the checker file of the key-value store.
`ifndef KV_CACHE_REPLACEMENT_DEFINES_SVH
`define KV_CACHE_REPLACEMENT_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define KVCR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define KVCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/kvcr_pkg.sv =====
`default_nettype none

package kvcr_pkg;

    // Default number of slots.
    localparam int ENTRIES_DEF = 8;

    // Field widths.
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int LFSR_W = 16;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int POL_W      = 2;
    localparam int CAP_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd1;

    localparam logic [POL_W-1:0] POL_LRU    = 2'd0;
    localparam logic [POL_W-1:0] POL_FIFO   = 2'd1;
    localparam logic [POL_W-1:0] POL_RANDOM = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Write enables of the key and value memories.
    typedef struct packed {
        logic key;
        logic val;
    } t_wr_en;

endpackage

`default_nettype wire

// ===== rtl/kvcr_if.sv =====
`default_nettype none

// Request channel: one get or put.
interface kvcr_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;

    modport source (output valid, output mode, output lookup_key, output store_value,
                    input ready);
    modport sink   (input valid, input mode, input lookup_key, input store_value,
                    output ready);
endinterface

// Response channel: one result per request.
interface kvcr_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

`default_nettype wire

// ===== rtl/kv_cache_replacement.sv =====
// A get hit passes SCAN, DECIDE and VALRD before DONE; a miss or a put into a free slot goes
// from DECIDE to DONE, and a put that evicts waits in VWAIT for the serial remainder, then
// passes VSCAN, VREAD and VKEY. One request is taken at a time.
// A new request is taken only once the last result has moved to the output register; a
// response still waiting for the sink holds that move.
// Reset (synchronous, active low) empties the store at once; no clearing pass.
`default_nettype none

// Fully associative key-value store with LRU, FIFO or pseudo-random replacement.
//
// A request is handled by a small sequencer around one shared key comparator:
//   SCAN    the keys are read from the key memory one slot per cycle and compared
//           against the request key; the first match and the first free slot are
//           recorded. The read data is registered, so each key is compared in the cycle after its read.
//   DECIDE  hit, miss, insertion into a free slot or eviction is settled here. All
//           writes for a hit or a plain insertion happen in this cycle.
//   VWAIT   an eviction waits for the serial remainder unit, which was started at
//           the request transfer with the LFSR and the fill count.
//   VSCAN   the age ranks are swept one slot per cycle to find the victim.
//   VREAD / VKEY  the victim key is read back, and the new entry takes its slot.
//   VALRD   the stored value of a get hit is read.
//   DONE    the result moves to the output register once it is free.
//
// Every valid slot carries an age rank: 0 is the newest (or most recently used under LRU)
// entry. Promotion and eviction reduce to the same update: the chosen slot becomes rank 0
// and valid slots younger than its old rank age by one; a free-slot insert ages them all.
module kv_cache_replacement
    import kvcr_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    kvcr_in_if.sink               i_req,
    kvcr_out_if.source            o_rsp
);

    // Slot index, age rank and fill count widths.
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = IW;
    localparam int FW = $clog2(ENTRIES + 1);
    localparam int EW = (FW > CAP_W) ? FW : CAP_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_VWAIT,
        S_VSCAN,
        S_VREAD,
        S_VKEY,
        S_VALRD,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [POL_W-1:0] r_policy;
    logic [CAP_W-1:0] r_cap;

    // Store state.
    logic [ENTRIES-1:0] r_valid;
    logic [OW-1:0]      r_order [ENTRIES];
    logic [FW-1:0]      r_fill;
    logic [LFSR_W-1:0]  r_lfsr;

    // Request being worked on.
    logic                    r_mode;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_val;

    // Scan bookkeeping.
    logic [FW-1:0] r_cnt;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    logic          r_found;
    logic [IW-1:0] r_slot;
    logic          r_free_ok;
    logic [IW-1:0] r_free;
    logic [OW-1:0] r_target;
    logic          r_vfound;
    logic [IW-1:0] r_vslot;

    // Result held until the output register is free.
    logic                    r_res_hit;
    logic signed [VAL_W-1:0] r_res_rd;
    logic                    r_res_ev;
    logic signed [KEY_W-1:0] r_res_evk;

    // Output register.
    logic                    r_o_vld;
    logic                    r_o_hit;
    logic signed [VAL_W-1:0] r_o_rd;
    logic                    r_o_ev;
    logic signed [KEY_W-1:0] r_o_evk;

    // Store interface.
    t_wr_en           w_we;
    logic [IW-1:0]    w_key_raddr;
    logic [KEY_W-1:0] w_key_q;
    logic [VAL_W-1:0] w_val_q;

    // Remainder unit.
    logic          w_rem_start;
    logic          w_rem_done;
    logic [FW-1:0] w_rem;

    // Commit controls.
    logic          w_accept;
    logic          w_ins_free;
    logic          w_ins;
    logic          w_hit_put;
    logic          w_upd;
    logic          w_upd_all;
    logic [IW-1:0] w_slot;
    logic [OW-1:0] w_age;
    logic [EW-1:0] w_cap_eff;
    logic          w_full;
    logic [FW-1:0] w_target;
    logic          w_key_eq;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_rem_start = w_accept;

    // Capacity zero acts as one, and anything above the slot count as the slot count.
    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = EW'(1);
        end else if (EW'(r_cap) > EW'(ENTRIES)) begin
            w_cap_eff = EW'(ENTRIES);
        end else begin
            w_cap_eff = EW'(r_cap);
        end
        w_full = (EW'(r_fill) >= w_cap_eff) && (r_fill != '0);
    end

    // The random index counts from the oldest insertion; the others take the oldest.
    always_comb begin
        if (r_policy == POL_RANDOM) begin
            w_target = r_fill - FW'(1) - w_rem;
        end else begin
            w_target = r_fill - FW'(1);
        end
    end

    // The shared comparator of the key scan.
    assign w_key_eq = (w_key_q == r_key);

    always_comb begin
        w_ins_free = (r_state == S_DECIDE) && !r_found && (r_mode == MODE_PUT) && !w_full;
        w_ins      = w_ins_free || (r_state == S_VKEY);
        w_hit_put  = (r_state == S_DECIDE) && r_found && (r_mode == MODE_PUT);
        w_upd      = w_ins || ((r_state == S_DECIDE) && r_found && (r_policy == POL_LRU));
        w_upd_all  = w_ins_free;
        if (r_state == S_VKEY) begin
            w_slot = r_vslot;
        end else if (r_found) begin
            w_slot = r_slot;
        end else begin
            w_slot = r_free;
        end
        w_age       = r_order[w_slot];
        w_we.key    = w_ins;
        w_we.val    = w_ins || w_hit_put;
        w_key_raddr = (r_state == S_VREAD) ? r_vslot : r_cnt[IW-1:0];
    end

    kvcr_store #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (w_we),
        .i_wr_addr   (w_slot),
        .i_wr_key    (r_key),
        .i_wr_val    (r_val),
        .i_key_raddr (w_key_raddr),
        .i_val_raddr (r_slot),
        .o_key_q     (w_key_q),
        .o_val_q     (w_val_q)
    );

    kvcr_rem #(
        .NUM_W (LFSR_W),
        .DEN_W (FW)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rem_start),
        .i_num   (r_lfsr),
        .i_den   (r_fill),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_LRU;
            r_cap    <= CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY:   r_policy <= i_cfg_data[POL_W-1:0];
                CFG_CAPACITY: r_cap    <= i_cfg_data[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Valid bits, age ranks, fill count and LFSR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
            r_lfsr  <= LFSR_SEED;
            for (int i = 0; i < ENTRIES; i++) begin
                r_order[i] <= '0;
            end
        end else begin
            if (w_upd) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == w_slot) begin
                        r_order[i] <= '0;
                    end else if (r_valid[i] && (w_upd_all || (r_order[i] < w_age))) begin
                        r_order[i] <= r_order[i] + 1'b1;
                    end
                end
            end
            if (w_ins) begin
                r_valid[w_slot] <= 1'b1;
            end
            if (w_ins_free) begin
                r_fill <= r_fill + 1'b1;
            end
            if ((r_state == S_VKEY) && (r_policy == POL_RANDOM)) begin
                r_lfsr <= {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5],
                           r_lfsr[LFSR_W-1:1]};
            end
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o_vld <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            // In DONE the load below takes care of a transfer out of the register.
            if (r_o_vld && o_rsp.ready && (r_state != S_DONE)) begin
                r_o_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode    <= i_req.mode;
                        r_key     <= i_req.lookup_key;
                        r_val     <= i_req.store_value;
                        r_cnt     <= '0;
                        r_pv      <= 1'b0;
                        r_found   <= 1'b0;
                        r_slot    <= '0;
                        r_free_ok <= 1'b0;
                        r_free    <= '0;
                        r_res_hit <= 1'b0;
                        r_res_rd  <= '0;
                        r_res_ev  <= 1'b0;
                        r_res_evk <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Issue one key read per cycle; compare the previous read.
                    r_pv   <= (r_cnt < FW'(ENTRIES));
                    r_pidx <= r_cnt[IW-1:0];
                    if (r_cnt < FW'(ENTRIES)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_pv) begin
                        if (r_valid[r_pidx] && w_key_eq && !r_found) begin
                            r_found <= 1'b1;
                            r_slot  <= r_pidx;
                        end
                        if (!r_valid[r_pidx] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_pidx;
                        end
                    end else if (r_cnt == FW'(ENTRIES)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_res_hit <= r_found;
                    if (r_found) begin
                        r_state <= (r_mode == MODE_GET) ? S_VALRD : S_DONE;
                    end else if (r_mode == MODE_GET) begin
                        r_res_rd <= '1;
                        r_state  <= S_DONE;
                    end else if (w_full) begin
                        r_state <= S_VWAIT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_VWAIT: begin
                    if (w_rem_done) begin
                        r_target <= w_target[OW-1:0];
                        r_cnt    <= '0;
                        r_vfound <= 1'b0;
                        r_vslot  <= '0;
                        r_state  <= S_VSCAN;
                    end
                end
                S_VSCAN: begin
                    if (r_valid[r_cnt[IW-1:0]] && (r_order[r_cnt[IW-1:0]] == r_target)
                        && !r_vfound) begin
                        r_vfound <= 1'b1;
                        r_vslot  <= r_cnt[IW-1:0];
                    end
                    if (r_cnt == FW'(ENTRIES - 1)) begin
                        r_state <= S_VREAD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_VREAD: begin
                    r_state <= S_VKEY;
                end
                S_VKEY: begin
                    r_res_ev  <= 1'b1;
                    r_res_evk <= w_key_q;
                    r_state   <= S_DONE;
                end
                S_VALRD: begin
                    r_res_rd <= w_val_q;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_vld || o_rsp.ready) begin
                        r_o_vld <= 1'b1;
                        r_o_hit <= r_res_hit;
                        r_o_rd  <= r_res_rd;
                        r_o_ev  <= r_res_ev;
                        r_o_evk <= r_res_evk;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_o_vld;
    assign o_rsp.hit         = r_o_hit;
    assign o_rsp.read_value  = r_o_rd;
    assign o_rsp.evicted     = r_o_ev;
    assign o_rsp.evicted_key = r_o_evk;

endmodule

`default_nettype wire

// ===== rtl/kvcr_rem.sv =====
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module kvcr_rem
    import kvcr_pkg::*;
#(
    parameter int NUM_W = LFSR_W,
    parameter int DEN_W = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [NUM_W-1:0]  i_num,
    input  wire [DEN_W-1:0]  i_den,
    output logic             o_done,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;

    always_comb begin
        w_shift = {r_rem, r_num[NUM_W-1]};
        w_diff  = w_shift - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_num  <= i_num;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (w_shift >= {1'b0, i_den}) begin
                r_rem <= w_diff[DEN_W-1:0];
            end else begin
                r_rem <= w_shift[DEN_W-1:0];
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/kvcr_store.sv =====
`default_nettype none

// Key and value memories, one write and one registered read port each.
module kvcr_store
    import kvcr_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IW      = 3
) (
    input  wire              i_clk,
    input  wire t_wr_en      i_we,
    input  wire [IW-1:0]     i_wr_addr,
    input  wire [KEY_W-1:0]  i_wr_key,
    input  wire [VAL_W-1:0]  i_wr_val,
    input  wire [IW-1:0]     i_key_raddr,
    input  wire [IW-1:0]     i_val_raddr,
    output logic [KEY_W-1:0] o_key_q,
    output logic [VAL_W-1:0] o_val_q
);

    logic [KEY_W-1:0] r_key_mem [ENTRIES];
    logic [VAL_W-1:0] r_val_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we.key) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        o_key_q <= r_key_mem[i_key_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.val) begin
            r_val_mem[i_wr_addr] <= i_wr_val;
        end
        o_val_q <= r_val_mem[i_val_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/kvcr_checker.sv =====
`default_nettype none

`include "kv_cache_replacement_defines.svh"

module kvcr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_out_hit,
    input wire        i_out_evicted,
    input wire [31:0] i_out_evicted_key
);

    // A response waiting for its transfer stays valid and keeps its evicted key.
    `KVCR_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_evicted_key), "response dropped or changed while stalled")

    // One request at a time: the store is busy right after a transfer.
    `KVCR_ASSERT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "request taken while busy")

    // An eviction only follows a miss.
    `KVCR_ASSERT(a_evict_on_miss, i_clk, i_rst_n, i_out_valid && i_out_evicted |-> !i_out_hit, "eviction reported on a hit")

    // The evicted key reads zero when nothing was evicted.
    `KVCR_ASSERT(a_evkey_zero, i_clk, i_rst_n, i_out_valid && !i_out_evicted |-> i_out_evicted_key == 32'd0, "evicted key not zero")

    // No response survives reset.
    `KVCR_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_out_valid, "response valid after reset")

endmodule

bind kv_cache_replacement kvcr_checker u_kvcr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_out_hit         (o_rsp.hit),
    .i_out_evicted     (o_rsp.evicted),
    .i_out_evicted_key (o_rsp.evicted_key)
);

`default_nettype wire
